/* rtl/mtc_pkg.sv */
// Shared types and constants for the machine timer with compare.
package mtc_pkg;

  // Item opcodes
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_WRITE_TIME = 3'd1;
  localparam logic [2:0] OP_WRITE_MCMP = 3'd2;
  localparam logic [2:0] OP_WRITE_SCMP = 3'd3;
  localparam logic [2:0] OP_WRITE_GCMP = 3'd4;
  localparam logic [2:0] OP_WAIT       = 3'd5;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_PRESCALE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_DELTA    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SEN      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_GEN      = 3'd4;

  // Configuration reset values
  localparam logic [15:0] PRESCALE_RST = 16'd1;
  localparam logic [31:0] TIMEOUT_RST  = 32'd1000;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [15:0] prescale_divisor;
    logic [31:0] wfi_timeout;
    logic [63:0] hyper_time_delta;
    logic        supervisor_timer_enable;
    logic        guest_timer_enable;
  } mtc_cfg_t;

  // Architectural timer state
  typedef struct packed {
    logic [63:0] time_count;
    logic [63:0] machine_compare;
    logic [63:0] supervisor_compare;
    logic [63:0] guest_compare;
  } mtc_state_t;

endpackage

/* rtl/mtc_core.sv */
// Timer state registers and their per-item update (tick, writes, wait).
module mtc_core #(
  parameter int unsigned PRESCALE_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [2:0]         op,
  input  logic [63:0]        val,
  input  mtc_pkg::mtc_cfg_t  cfg,
  output mtc_pkg::mtc_state_t st
);

  localparam int unsigned CMP_W = (PRESCALE_WIDTH + 1 > 16) ? PRESCALE_WIDTH + 1 : 16;

  logic [PRESCALE_WIDTH-1:0] pcount_r, pcount_nxt;
  mtc_pkg::mtc_state_t       st_r, st_nxt;

  logic [CMP_W-1:0] pc_inc;
  logic [CMP_W-1:0] div_eff;
  logic             tick_wrap;

  logic [63:0] guest_time;
  logic [63:0] d_m, d_s, d_g, tmo;
  logic        m_ok, s_ok, g_ok;
  logic [63:0] ms_min, gt_min, jump;
  logic        ms_ok;

  // Prescale compare in full width; a zero divisor counts as one
  always_comb begin
    pc_inc  = CMP_W'(pcount_r) + CMP_W'(1);
    div_eff = (cfg.prescale_divisor == 16'd0) ? CMP_W'(1) : CMP_W'(cfg.prescale_divisor);
    tick_wrap = (pc_inc >= div_eff);
  end

  // Distances to each compare that has not yet passed
  always_comb begin
    guest_time = st_r.time_count + cfg.hyper_time_delta;
    tmo  = {32'd0, cfg.wfi_timeout};
    d_m  = st_r.machine_compare - st_r.time_count;
    d_s  = st_r.supervisor_compare - st_r.time_count;
    d_g  = st_r.guest_compare - guest_time;
    m_ok = (st_r.time_count <= st_r.machine_compare);
    s_ok = cfg.supervisor_timer_enable && (st_r.time_count <= st_r.supervisor_compare);
    g_ok = cfg.guest_timer_enable && (guest_time <= st_r.guest_compare);
  end

  // Pick the smallest distance with a two-level tree
  always_comb begin
    if (m_ok && (!s_ok || d_m < d_s)) begin
      ms_min = d_m;
    end else begin
      ms_min = d_s;
    end
    ms_ok  = m_ok || s_ok;
    gt_min = (g_ok && d_g < tmo) ? d_g : tmo;
    jump   = (ms_ok && ms_min < gt_min) ? ms_min : gt_min;
  end

  // Apply one item to the state
  always_comb begin
    st_nxt     = st_r;
    pcount_nxt = pcount_r;
    if (go) begin
      unique case (op)
        mtc_pkg::OP_TICK: begin
          if (tick_wrap) begin
            pcount_nxt         = '0;
            st_nxt.time_count  = st_r.time_count + 64'd1;
          end else begin
            pcount_nxt = pc_inc[PRESCALE_WIDTH-1:0];
          end
        end
        mtc_pkg::OP_WRITE_TIME: st_nxt.time_count         = val;
        mtc_pkg::OP_WRITE_MCMP: st_nxt.machine_compare    = val;
        mtc_pkg::OP_WRITE_SCMP: st_nxt.supervisor_compare = val;
        mtc_pkg::OP_WRITE_GCMP: st_nxt.guest_compare      = val;
        mtc_pkg::OP_WAIT:       st_nxt.time_count         = st_r.time_count + jump;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r                <= '0;
      st_r.time_count         <= '0;
      st_r.machine_compare    <= '1;
      st_r.supervisor_compare <= '1;
      st_r.guest_compare      <= '1;
    end else begin
      pcount_r <= pcount_nxt;
      st_r     <= st_nxt;
    end
  end

  assign st = st_r;

  // A tick that does not wrap never leaves the prescale count at zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (go && op == mtc_pkg::OP_TICK && !tick_wrap) |=> (pcount_r != '0 || PRESCALE_WIDTH == 0))
    else $error("prescale count cleared without wrap");
  assert property (@(posedge clk) disable iff (!rst_n)
    (go && op == mtc_pkg::OP_WAIT) |=> ((st_r.time_count - $past(st_r.time_count)) <= 64'($past(cfg.wfi_timeout))))
    else $error("wait jumped past timeout");
  assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> $stable(st_r) && $stable(pcount_r))
    else $error("state changed without an item");

endmodule

/* rtl/mtc_result.sv */
// Result register: time and pending flags taken from the updated state.
module mtc_result (
  input  logic                clk,
  input  logic                load,
  input  mtc_pkg::mtc_cfg_t   cfg,
  input  mtc_pkg::mtc_state_t st,
  output logic [63:0]         current_time,
  output logic                machine_pending,
  output logic                supervisor_pending,
  output logic                guest_pending,
  output logic [7:0]          pending_image
);

  logic [63:0] time_r;
  logic        mp_r, sp_r, gp_r;
  logic [63:0] guest_time;
  logic        mp, sp, gp;

  // Compare time and guest time against the compares
  always_comb begin
    guest_time = st.time_count + cfg.hyper_time_delta;
    mp = (st.time_count >= st.machine_compare);
    sp = cfg.supervisor_timer_enable && (st.time_count >= st.supervisor_compare);
    gp = cfg.guest_timer_enable && (guest_time >= st.guest_compare);
  end

  // Hold the result until the next load
  always_ff @(posedge clk) begin
    if (load) begin
      time_r <= st.time_count;
      mp_r   <= mp;
      sp_r   <= sp;
      gp_r   <= gp;
    end
  end

  assign current_time       = time_r;
  assign machine_pending    = mp_r;
  assign supervisor_pending = sp_r;
  assign guest_pending      = gp_r;
  assign pending_image      = {mp_r, gp_r, sp_r, 5'd0};

endmodule

/* rtl/machine_timer_with_compare.sv */
// Top level of the machine timer with compare: input register, control, config.
//
// Usage: each input item carries an opcode (tick, write time, write machine,
// supervisor or guest compare, wait for interrupt) and a 64-bit write value.
// Every item produces exactly one result item: the time after the item and
// the machine, supervisor and guest pending flags plus their mip-style image.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. Configuration registers are written through cfg_we/cfg_addr/cfg_wdata;
// the user must write them only while no item is in flight, which the block
// itself does not enforce. An accepted item passes the input register, the
// state update and the result register before its result shows on out_valid.
// Throughput: one item per cycle while the receiver does not stall; the timer
// state loop (time counter, wait-jump adder/min tree) holds one register, so
// items follow back to back. When the receiver stalls, up to three items stay
// in flight and in_stall rises only once the input register cannot drain.
// Reset (synchronous, rst_n low): time and prescale count go to zero, all
// compares to all ones, config to its defaults, and all stages empty.
module machine_timer_with_compare #(
  parameter int unsigned PRESCALE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_opcode,
  input  logic [63:0]                    in_write_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [63:0]                    out_current_time,
  output logic                           out_machine_pending,
  output logic                           out_supervisor_pending,
  output logic                           out_guest_pending,
  output logic [7:0]                     out_pending_image,
  input  logic                           cfg_we,
  input  logic [mtc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [63:0]                    cfg_wdata
);

  logic              a_v_r, a_v_nxt;
  logic [2:0]        a_op_r;
  logic [63:0]       a_val_r;
  logic              b_v_r, b_v_nxt;
  logic              out_v_r, out_v_nxt;
  mtc_pkg::mtc_cfg_t cfg_r, cfg_nxt;
  mtc_pkg::mtc_state_t st;

  logic out_adv, b_go, b_free, a_go, in_acc;

  // Flow control along the three stages
  always_comb begin
    out_adv = !out_v_r || !out_stall;
    b_go    = b_v_r && out_adv;
    b_free  = !b_v_r || out_adv;
    a_go    = a_v_r && b_free;
    in_stall = a_v_r && !b_free;
    in_acc  = in_valid && !in_stall;
    a_v_nxt   = in_acc ? 1'b1 : (a_go ? 1'b0 : a_v_r);
    b_v_nxt   = a_go ? 1'b1 : (b_go ? 1'b0 : b_v_r);
    out_v_nxt = b_go ? 1'b1 : ((out_v_r && !out_stall) ? 1'b0 : out_v_r);
  end

  // Decode configuration writes; unknown indexes drop
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        mtc_pkg::CFG_PRESCALE: cfg_nxt.prescale_divisor        = cfg_wdata[15:0];
        mtc_pkg::CFG_TIMEOUT:  cfg_nxt.wfi_timeout             = cfg_wdata[31:0];
        mtc_pkg::CFG_DELTA:    cfg_nxt.hyper_time_delta        = cfg_wdata;
        mtc_pkg::CFG_SEN:      cfg_nxt.supervisor_timer_enable = cfg_wdata[0];
        mtc_pkg::CFG_GEN:      cfg_nxt.guest_timer_enable      = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      out_v_r <= 1'b0;
      cfg_r.prescale_divisor        <= mtc_pkg::PRESCALE_RST;
      cfg_r.wfi_timeout             <= mtc_pkg::TIMEOUT_RST;
      cfg_r.hyper_time_delta        <= '0;
      cfg_r.supervisor_timer_enable <= 1'b0;
      cfg_r.guest_timer_enable      <= 1'b0;
    end else begin
      a_v_r   <= a_v_nxt;
      b_v_r   <= b_v_nxt;
      out_v_r <= out_v_nxt;
      cfg_r   <= cfg_nxt;
    end
  end

  // Capture the item payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_op_r  <= in_opcode;
      a_val_r <= in_write_value;
    end
  end

  mtc_core #(
    .PRESCALE_WIDTH(PRESCALE_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (a_go),
    .op    (a_op_r),
    .val   (a_val_r),
    .cfg   (cfg_r),
    .st    (st)
  );

  mtc_result u_result (
    .clk                (clk),
    .load               (b_go),
    .cfg                (cfg_r),
    .st                 (st),
    .current_time       (out_current_time),
    .machine_pending    (out_machine_pending),
    .supervisor_pending (out_supervisor_pending),
    .guest_pending      (out_guest_pending),
    .pending_image      (out_pending_image)
  );

  assign out_valid = out_v_r;

  // An applied item always lands in the middle stage
  assert property (@(posedge clk) disable iff (!rst_n)
    a_go |=> b_v_r)
    else $error("applied item lost before result stage");
  // A blocked middle stage keeps its item
  assert property (@(posedge clk) disable iff (!rst_n)
    (b_v_r && !out_adv) |=> b_v_r)
    else $error("middle stage dropped an item");
  // State never moves while the middle stage is full and blocked
  assert property (@(posedge clk) disable iff (!rst_n)
    (b_v_r && !out_adv) |=> $stable(st))
    else $error("state changed under a pending result");
  // Input stall only when the input register holds an item
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> a_v_r)
    else $error("stall raised with empty input register");

endmodule
